/* hw/rtl/rlpenc_pkg.sv */
package rlpenc_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [63:0] ShortLimit    = 64'd56;
  localparam logic [7:0]  StrShortBase  = 8'h80;
  localparam logic [7:0]  ListShortBase = 8'hC0;
  localparam logic [7:0]  StrLongBase   = 8'hB7;
  localparam logic [7:0]  ListLongBase  = 8'hF7;
  localparam logic [7:0]  BoolTrueByte  = 8'h01;
  localparam logic [7:0]  SmallByteTop  = 8'h80;

  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_STRING = 2'd1,
    ACT_BOOL   = 2'd2
  } action_e;

  typedef struct packed {
    logic [1:0]  action;
    logic        is_list;
    logic [63:0] pay_len;
    logic [7:0]  data_byte;
    logic        first_of_string;
    logic        bool_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // one classified request: optional head byte, length bytes, optional data byte
  typedef struct packed {
    logic        head_vld;
    logic [7:0]  head_byte;
    logic [3:0]  len_cnt;
    logic [63:0] len;
    logic        data_vld;
    logic [7:0]  data_byte;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic push;
    logic pop;
  } q_status_t;

endpackage

/* hw/rtl/rlp_item_encoder_unit.sv */
// channel | direction | handshake                     | payload
// in      | input     | in_valid_i / in_ready_o       | in_item_i  (rlpenc_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i     | out_item_o (rlpenc_pkg::out_item_t)
//
// requests are classified in the cycle they arrive and enter a QueueDepth-entry queue
// the output gives one byte per cycle while requests wait and out_ready_i is high: a request
// gives an optional head byte, n length bytes (0 to 8) and an optional data byte, at most 10
// the first byte of a request accepted into an idle unit passes the queue, the current-request and the output register
// the input takes one request per cycle while the queue has room
// reset empties the queue and the output register; there is no clearing pass
// a stalled output holds its byte and the back end waits, the front keeps filling
module rlp_item_encoder_unit #(
  parameter int unsigned QueueDepth = rlpenc_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rlpenc_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rlpenc_pkg::out_item_t out_item_o
);
  import rlpenc_pkg::*;

  desc_t     push_desc;
  desc_t     q_desc;
  logic      push;
  logic      pop;
  logic      q_valid;
  q_status_t q_stat;

  rlpenc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .full_i     (q_stat.full),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  rlpenc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .desc_i   (push_desc),
    .pop_i    (pop),
    .valid_o  (q_valid),
    .desc_o   (q_desc),
    .status_o (q_stat)
  );

  rlpenc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_desc_i    (q_desc),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // queue never reports full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty together");

  // an unused action code never reaches the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.action != ACT_HEADER &&
     in_item_i.action != ACT_STRING && in_item_i.action != ACT_BOOL) |-> !q_stat.push)
    else $error("unused action pushed a request");

  // a push with no pop leaves the queue non-empty next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.push && !q_stat.pop) |=> !q_stat.empty)
    else $error("queue lost a pushed request");

  // the back end only pops while the queue holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

/* hw/rtl/rlpenc_front.sv */
module rlpenc_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rlpenc_pkg::in_item_t in_item_i,
  input  logic               full_i,
  output logic               push_o,
  output rlpenc_pkg::desc_t  desc_o
);
  import rlpenc_pkg::*;

  logic [3:0]  nbytes;
  logic        is_short;
  logic        needs_push;
  logic [63:0] len;
  logic [7:0]  str_head;
  logic [3:0]  str_cnt;
  logic [7:0]  list_head;
  desc_t       desc;

  assign len = in_item_i.pay_len;

  // count of significant bytes in the length
  always_comb begin
    nbytes = '0;
    for (int i = 0; i < 8; i++) begin
      if (len[8*i +: 8] != 8'h00) nbytes = 4'(i + 1);
    end
  end

  assign is_short  = len < ShortLimit;
  assign str_head  = is_short ? (StrShortBase + len[7:0]) : (StrLongBase + {4'b0, nbytes});
  assign list_head = is_short ? (ListShortBase + len[7:0]) : (ListLongBase + {4'b0, nbytes});
  assign str_cnt   = is_short ? 4'd0 : nbytes;

  always_comb begin
    desc           = '0;
    desc.len       = len;
    desc.data_byte = in_item_i.data_byte;
    needs_push     = 1'b1;
    case (in_item_i.action)
      ACT_HEADER: begin
        desc.head_vld  = 1'b1;
        desc.head_byte = in_item_i.is_list ? list_head : str_head;
        desc.len_cnt   = str_cnt;
      end
      ACT_STRING: begin
        if (!in_item_i.first_of_string) begin
          desc.data_vld = 1'b1;
        end else if (len == 64'd0) begin
          desc.head_vld  = 1'b1;
          desc.head_byte = StrShortBase;
        end else if (len == 64'd1 && in_item_i.data_byte < SmallByteTop) begin
          desc.data_vld = 1'b1;
        end else begin
          desc.head_vld  = 1'b1;
          desc.head_byte = str_head;
          desc.len_cnt   = str_cnt;
          desc.data_vld  = 1'b1;
        end
      end
      ACT_BOOL: begin
        desc.head_vld  = 1'b1;
        desc.head_byte = in_item_i.bool_value ? BoolTrueByte : StrShortBase;
      end
      default: begin
        // unused action code produces no output
        needs_push = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i && needs_push;
  assign desc_o     = desc;

endmodule

/* hw/rtl/rlpenc_queue.sv */
module rlpenc_queue #(
  parameter int unsigned Depth = rlpenc_pkg::QueueDepthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rlpenc_pkg::desc_t     desc_i,
  input  logic                  pop_i,
  output logic                  valid_o,
  output rlpenc_pkg::desc_t     desc_o,
  output rlpenc_pkg::q_status_t status_o
);
  import rlpenc_pkg::*;

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  desc_t            entries_q [Depth];
  logic [IdxW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;

  assign full    = count_q == CntW'(Depth);
  assign empty   = count_q == '0;
  assign do_push = push_i && !full;
  assign do_pop  = pop_i && !empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == IdxW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == IdxW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wr_ptr_q] <= desc_i;
  end

  assign valid_o  = !empty;
  assign desc_o   = entries_q[rd_ptr_q];
  assign status_o = '{full: full, empty: empty, push: do_push, pop: do_pop};

endmodule

/* hw/rtl/rlpenc_back.sv */
module rlpenc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  rlpenc_pkg::desc_t     q_desc_i,
  output logic                  q_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output rlpenc_pkg::out_item_t out_item_o
);
  import rlpenc_pkg::*;

  logic        cur_vld_q, cur_vld_d;
  logic        head_pend_q, head_pend_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        data_pend_q, data_pend_d;
  logic [7:0]  head_q, head_d;
  logic [63:0] len_q, len_d;
  logic [7:0]  data_q, data_d;
  logic        out_vld_q, out_vld_d;
  out_item_t   out_q, out_d;

  logic        advance;
  logic        is_last;
  logic        load;
  logic [7:0]  next_byte;
  logic [2:0]  len_idx;

  assign len_idx = 3'(cnt_q - 4'd1);
  assign advance = cur_vld_q && (!out_vld_q || out_ready_i);

  // pick the next byte of the current request and see if it ends the run
  always_comb begin
    if (head_pend_q) begin
      next_byte = head_q;
      is_last   = (cnt_q == 4'd0) && !data_pend_q;
    end else if (cnt_q != 4'd0) begin
      next_byte = len_q[{len_idx, 3'b000} +: 8];
      is_last   = (cnt_q == 4'd1) && !data_pend_q;
    end else begin
      next_byte = data_q;
      is_last   = 1'b1;
    end
  end

  assign load    = q_valid_i && (!cur_vld_q || (advance && is_last));
  assign q_pop_o = load;

  always_comb begin
    cur_vld_d   = cur_vld_q;
    head_pend_d = head_pend_q;
    cnt_d       = cnt_q;
    data_pend_d = data_pend_q;
    head_d      = head_q;
    len_d       = len_q;
    data_d      = data_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    out_d       = out_q;

    if (advance) begin
      out_vld_d         = 1'b1;
      out_d.out_byte    = next_byte;
      out_d.last_of_run = is_last;
      if (head_pend_q) begin
        head_pend_d = 1'b0;
      end else if (cnt_q != 4'd0) begin
        cnt_d = cnt_q - 4'd1;
      end else begin
        data_pend_d = 1'b0;
      end
      if (is_last) cur_vld_d = 1'b0;
    end

    if (load) begin
      cur_vld_d   = 1'b1;
      head_pend_d = q_desc_i.head_vld;
      cnt_d       = q_desc_i.len_cnt;
      data_pend_d = q_desc_i.data_vld;
      head_d      = q_desc_i.head_byte;
      len_d       = q_desc_i.len;
      data_d      = q_desc_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q   <= 1'b0;
      head_pend_q <= 1'b0;
      cnt_q       <= '0;
      data_pend_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      cur_vld_q   <= cur_vld_d;
      head_pend_q <= head_pend_d;
      cnt_q       <= cnt_d;
      data_pend_q <= data_pend_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    len_q  <= len_d;
    data_q <= data_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* sim/rlp_item_encoder_unit_tb.sv */
module rlp_item_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlpenc_pkg::*;

  localparam logic [1:0] ActUnused     = 2'd3;
  localparam int         WatchdogLimit = 1000;
  localparam int         DrainCycles   = 24;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  out_item_t enc_bytes_q[$];
  logic [7:0] run_bytes [0:9];
  int        run_len;
  bit        no_idle;
  int        n_items;
  int        n_bytes;
  int        n_fail;
  int        stuck_cycles;

  rlp_item_encoder_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #2 clk_i = ~clk_i;

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 16);
  endfunction

  function automatic void add_prefix(logic is_list, logic [63:0] len);
    int nb;
    logic [63:0] t;
    if (len < ShortLimit) begin
      run_bytes[run_len] = (is_list ? ListShortBase : StrShortBase) + len[7:0];
      run_len++;
    end else begin
      nb = 0;
      t = len;
      while (t != 64'd0) begin
        nb++;
        t = t >> 8;
      end
      run_bytes[run_len] = (is_list ? ListLongBase : StrLongBase) + 8'(nb);
      run_len++;
      for (int i = nb - 1; i >= 0; i--) begin
        run_bytes[run_len] = len[8*i +: 8];
        run_len++;
      end
    end
  endfunction

  // fills run_bytes with the encoding one request causes
  function automatic void encode_item(in_item_t it);
    run_len = 0;
    case (it.action)
      ACT_HEADER: add_prefix(it.is_list, it.pay_len);
      ACT_STRING: begin
        if (it.first_of_string && it.pay_len == 64'd0) begin
          run_bytes[0] = StrShortBase;
          run_len = 1;
        end else begin
          if (it.first_of_string &&
              !(it.pay_len == 64'd1 && it.data_byte < SmallByteTop)) begin
            add_prefix(1'b0, it.pay_len);
          end
          run_bytes[run_len] = it.data_byte;
          run_len++;
        end
      end
      ACT_BOOL: begin
        run_bytes[0] = it.bool_value ? BoolTrueByte : StrShortBase;
        run_len = 1;
      end
      default: ;
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.action          = 2'($urandom_range(0, 3));
    it.is_list         = 1'($urandom_range(0, 1));
    it.pay_len         = {$urandom, $urandom};
    it.data_byte       = 8'($urandom);
    it.first_of_string = 1'($urandom_range(0, 1));
    it.bool_value      = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // random length with a random count of significant bytes
  function automatic logic [63:0] random_len();
    int nb;
    logic [63:0] v;
    nb = $urandom_range(0, 8);
    v = {$urandom, $urandom};
    if (nb < 8) v = v & ((64'd1 << (8 * nb)) - 64'd1);
    return v;
  endfunction

  task automatic send_req(in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    // ready is looked at mid-cycle, away from the edge that updates it
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
    encode_item(it);
    for (int i = 0; i < run_len; i++) begin
      enc_bytes_q.insert(enc_bytes_q.size(),
                         out_item_t'{out_byte: run_bytes[i], last_of_run: i == run_len - 1});
    end
    if (it.action != ActUnused) n_items++;
  endtask

  task automatic test_headers();
    logic [63:0] lens [9] = '{64'd0, 64'd55, 64'd55, 64'd56, 64'd56, 64'd255, 64'd256,
                             64'hFFFF_FFFF_FFFF_FFFF, 64'h0100_0000_0000_0000};
    in_item_t it;
    for (int i = 0; i < 9; i++) begin
      it = random_item();
      it.action = ACT_HEADER;
      it.is_list = 1'(i);
      it.pay_len = lens[i];
      send_req(it);
    end
  endtask

  task automatic test_strings();
    logic [63:0] lens  [9] = '{64'd0, 64'd1, 64'd1, 64'd1, 64'd1, 64'd2, 64'd0, 64'd56,
                              64'hFFFF_FFFF_FFFF_FFFF};
    logic [7:0]  datas [9] = '{8'h55, 8'h00, 8'h7F, 8'h80, 8'hFF, 8'h41, 8'hFF, 8'h00, 8'h12};
    bit          firsts[9] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    in_item_t it;
    for (int i = 0; i < 9; i++) begin
      it = random_item();
      it.action = ACT_STRING;
      it.first_of_string = firsts[i];
      it.data_byte = datas[i];
      // continuation keeps a junk length to show it is ignored
      if (firsts[i]) it.pay_len = lens[i];
      send_req(it);
    end
  endtask

  task automatic test_bools();
    in_item_t it;
    for (int i = 0; i < 2; i++) begin
      it = random_item();
      it.action = ACT_BOOL;
      it.bool_value = 1'(i);
      send_req(it);
    end
  endtask

  task automatic test_unused_action();
    in_item_t it;
    repeat (2) begin
      it = random_item();
      it.action = ActUnused;
      send_req(it);
    end
  endtask

  task automatic test_random_streams(int target);
    in_item_t it;
    int kind;
    int slen;
    while (n_items < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 1) begin
        it = random_item();
        it.action = ACT_HEADER;
        it.pay_len = random_len();
        send_req(it);
      end else if (kind <= 5) begin
        // well-formed string: first byte carries the length, the rest follow
        slen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 6);
        it = random_item();
        it.action = ACT_STRING;
        it.first_of_string = 1'b1;
        it.pay_len = 64'(slen);
        if (slen == 1 && $urandom_range(0, 1) == 1) it.data_byte[7] = 1'b0;
        send_req(it);
        for (int k = 1; k < slen && n_items < target; k++) begin
          it = random_item();
          it.action = ACT_STRING;
          it.first_of_string = 1'b0;
          send_req(it);
        end
      end else if (kind == 6) begin
        // long string cut short
        it = random_item();
        it.action = ACT_STRING;
        it.first_of_string = 1'b1;
        it.pay_len = random_len();
        send_req(it);
        repeat ($urandom_range(0, 3)) begin
          it = random_item();
          it.action = ACT_STRING;
          it.first_of_string = 1'b0;
          send_req(it);
        end
      end else if (kind == 7) begin
        it = random_item();
        it.action = ACT_BOOL;
        send_req(it);
      end else begin
        send_req(random_item());
      end
    end
    no_idle = 1'b0;
  endtask

  // output side: random stall before each byte, then compare
  initial begin : byte_sink
    int stall;
    out_item_t want;
    out_item_t got;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(negedge clk_i);
      while (!out_valid) @(negedge clk_i);
      got = out_item;
      @(posedge clk_i);
      if (enc_bytes_q.size() == 0) begin
        $error("unexpected output byte %02h", got.out_byte);
        n_fail++;
      end else begin
        want = enc_bytes_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
          n_fail++;
        end
        if (got.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                 got.last_of_run);
          n_fail++;
        end
        n_bytes++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("FAIL rlp_item_encoder_unit");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_headers();
    test_strings();
    test_bools();
    test_unused_action();
    test_random_streams(n_items + 100);
    in_valid <= 1'b0;
    while (enc_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("encoded %0d requests (headers, strings, bools) into %0d checked bytes",
             n_items, n_bytes);
    if (n_fail == 0) begin
      $display("PASS rlp_item_encoder_unit");
    end else begin
      $display("FAIL rlp_item_encoder_unit");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rlpenc_pkg.sv
hw/rtl/rlpenc_front.sv
hw/rtl/rlpenc_queue.sv
hw/rtl/rlpenc_back.sv
hw/rtl/rlp_item_encoder_unit.sv
sim/rlp_item_encoder_unit_tb.sv
